// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the modem bit engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define AMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define AMB_ASSERT_NEXT(lbl, pre, post, msg) \
  `AMB_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/core/amb_pkg.sv =====
// Shared constants and types of the modem bit engine.
package amb_pkg;

  localparam int unsigned WORD_BITS_DEF = 16;
  localparam int unsigned HIST_W        = 32;
  localparam int unsigned SUM_W         = 16;

  // Configuration port.
  localparam int unsigned AMB_PADDR_W = 3;
  localparam int unsigned AMB_DATA_W  = 32;
  localparam logic [AMB_PADDR_W-3:0] REG_SOFT_DCD = '0;

  // Modem control codes.
  localparam logic [3:0] CTRL_RX = 4'h0d;
  localparam logic [3:0] CTRL_TX = 4'h0e;

  // Sample divisors.
  localparam logic [3:0] DIV_TX       = 4'd12;
  localparam logic [3:0] DIV_SOFT_MID = 4'd4;
  localparam logic [3:0] DIV_SOFT_EARLY = 4'd5;
  localparam logic [3:0] DIV_SOFT_LATE  = 4'd3;
  localparam logic [3:0] DIV_HW_MID   = 4'd6;
  localparam logic [3:0] DIV_HW_EARLY = 4'd7;
  localparam logic [3:0] DIV_HW_LATE  = 4'd5;

  // Carrier-detect interval and arbitration period.
  localparam logic [7:0] DCD_IVL_SOFT = 8'd240;
  localparam logic [7:0] DCD_IVL_HW   = 8'd12;
  localparam logic [7:0] ARB_SOFT     = 8'd36;
  localparam logic [7:0] ARB_HW       = 8'd24;
  localparam logic [SUM_W-1:0] DCD_SEED = 16'd2;

  typedef struct packed {
    logic              rx_tick;
    logic [HIST_W-1:0] hist;
  } dcd_in_t;

  typedef struct packed {
    logic valid;
    logic carrier;
  } dcd_out_t;

endpackage

// ===== rtl/core/amb_apb_regs.sv =====
// APB configuration register of the modem bit engine.
module amb_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [amb_pkg::AMB_PADDR_W-1:0] paddr,
  input  logic [amb_pkg::AMB_DATA_W-1:0]  pwdata,
  output logic [amb_pkg::AMB_DATA_W-1:0]  prdata,
  output logic                           pready,
  output logic                           soft_dcd_o
);
  import amb_pkg::*;

  logic soft_dcd_q, soft_dcd_d;
  logic sel_soft;

  assign sel_soft = (paddr[AMB_PADDR_W-1:2] == REG_SOFT_DCD);
  assign pready   = 1'b1;

  always_comb begin
    soft_dcd_d = soft_dcd_q;
    if (psel && penable && pwrite && pready && sel_soft) begin
      soft_dcd_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soft_dcd_q <= 1'b0;
    end else begin
      soft_dcd_q <= soft_dcd_d;
    end
  end

  assign prdata     = sel_soft ? AMB_DATA_W'(soft_dcd_q) : '0;
  assign soft_dcd_o = soft_dcd_q;

endmodule

// ===== rtl/core/amb_dcd.sv =====
// Carrier-detect window sums and interval countdown.
module amb_dcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              soft_i,
  input  amb_pkg::dcd_in_t  dcd_i,
  output amb_pkg::dcd_out_t dcd_o
);
  import amb_pkg::*;

  logic [SUM_W-1:0] now_q, now_d, prev_q, prev_d, older_q, older_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0] evid, sum1, sum2, eval_sum;
  logic [2:0]       pos;
  logic [1:0]       neg;
  logic [7:0]       ivl;
  logic signed [SUM_W+1:0] total;
  logic             fire;

  // Evidence for one pass; it is added twice per receive tick.
  always_comb begin
    pos  = {2'b00, dcd_i.hist[1]};
    // a lone transition in the history ignores the oldest bit
    if (dcd_i.hist[HIST_W-2:1] == '0) begin
      pos = pos + 3'd2;
    end
    neg  = {1'b0, dcd_i.hist[2]} + {1'b0, dcd_i.hist[3]} + {1'b0, dcd_i.hist[4]};
    evid = '0;
    if (dcd_i.hist[0]) begin
      if (soft_i) begin
        evid = SUM_W'({pos, 4'b0000}) - SUM_W'(neg);
      end else begin
        evid = '1;
      end
    end
  end

  assign sum1     = now_q + evid;
  assign sum2     = sum1 + evid;
  assign ivl      = soft_i ? DCD_IVL_SOFT : DCD_IVL_HW;
  assign fire     = (cnt_q == 8'd0) || (cnt_q == 8'd1);
  assign eval_sum = (cnt_q == 8'd0) ? sum1 : sum2;
  assign total    = {{2{eval_sum[SUM_W-1]}}, eval_sum} + {{2{prev_q[SUM_W-1]}}, prev_q}
                  + {{2{older_q[SUM_W-1]}}, older_q};

  always_comb begin
    now_d   = now_q;
    prev_d  = prev_q;
    older_d = older_q;
    cnt_d   = cnt_q;
    if (adv_i && dcd_i.rx_tick) begin
      if (cnt_q == 8'd0) begin
        // evaluate before the second pass: the new window gets one pass
        older_d = prev_q;
        prev_d  = sum1;
        now_d   = DCD_SEED + evid;
        cnt_d   = ivl - 8'd2;
      end else if (cnt_q == 8'd1) begin
        older_d = prev_q;
        prev_d  = sum2;
        now_d   = DCD_SEED;
        cnt_d   = ivl - 8'd1;
      end else begin
        now_d   = sum2;
        cnt_d   = cnt_q - 8'd2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      prev_q  <= '0;
      older_q <= '0;
      cnt_q   <= '0;
    end else begin
      now_q   <= now_d;
      prev_q  <= prev_d;
      older_q <= older_d;
      cnt_q   <= cnt_d;
    end
  end

  assign dcd_o.valid   = dcd_i.rx_tick && fire;
  assign dcd_o.carrier = dcd_i.rx_tick && fire && total[SUM_W+1];

endmodule

// ===== rtl/core/amb_bit_core.sv =====
// NRZI coding, bit clock recovery and arbitration timing of the bit engine.
module amb_bit_core #(
  parameter int unsigned WORD_BITS = amb_pkg::WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 soft_i,
  input  logic                 transmitting_i,
  input  logic                 line_sample_i,
  input  logic [WORD_BITS-1:0] next_tx_word_i,
  output amb_pkg::dcd_in_t     dcd_o,
  output logic [3:0]           modem_control_o,
  output logic [3:0]           next_divisor_o,
  output logic                 tx_word_taken_o,
  output logic [WORD_BITS-1:0] rx_word_o,
  output logic                 rx_word_valid_o,
  output logic                 arbitrate_o
);
  import amb_pkg::*;

  logic [WORD_BITS:0]  bs_q, bs_d, bs_t, bs_s;
  logic                tx_level_q, tx_level_d;
  logic                prev_sample_q, prev_sample_d;
  logic                prev_rx_q, prev_rx_d;
  logic [HIST_W-1:0]   hist_q, hist_d, hist_rx;
  logic [1:0]          phase_q, phase_d;
  logic [7:0]          arb_q, arb_d;
  logic [7:0]          arb_reload;

  assign hist_rx    = {hist_q[HIST_W-2:0], line_sample_i ^ prev_sample_q};
  assign arb_reload = soft_i ? ARB_SOFT : ARB_HW;

  always_comb begin
    bs_d            = bs_q;
    tx_level_d      = tx_level_q;
    prev_sample_d   = prev_sample_q;
    prev_rx_d       = prev_rx_q;
    hist_d          = hist_q;
    phase_d         = phase_q;
    arb_d           = arb_q;
    bs_t            = bs_q;
    bs_s            = bs_q;
    modem_control_o = CTRL_RX;
    next_divisor_o  = DIV_TX;
    tx_word_taken_o = 1'b0;
    rx_word_o       = '0;
    rx_word_valid_o = 1'b0;
    arbitrate_o     = 1'b0;
    if (transmitting_i) begin
      modem_control_o = CTRL_TX | {3'b000, tx_level_q};
      // reload when only the marker or nothing is left
      if (bs_q[WORD_BITS:1] == '0) begin
        bs_t            = {1'b1, next_tx_word_i};
        tx_word_taken_o = 1'b1;
      end
      tx_level_d = ~(tx_level_q ^ bs_t[0]);
      bs_d       = {1'b0, bs_t[WORD_BITS:1]};
      if (arb_q == 8'd0) begin
        arb_d       = arb_reload;
        arbitrate_o = 1'b1;
      end
    end else begin
      hist_d        = hist_rx;
      prev_sample_d = line_sample_i;
      if (phase_q != 2'd0) begin
        next_divisor_o = soft_i ? DIV_SOFT_MID : DIV_HW_MID;
      end else begin
        if (soft_i) begin
          case (hist_rx[2:0])
            3'd1:    next_divisor_o = DIV_SOFT_EARLY;
            3'd4:    next_divisor_o = DIV_SOFT_LATE;
            default: next_divisor_o = DIV_SOFT_MID;
          endcase
        end else begin
          case (hist_rx[1:0])
            2'd1:    next_divisor_o = DIV_HW_EARLY;
            2'd2:    next_divisor_o = DIV_HW_LATE;
            default: next_divisor_o = DIV_HW_MID;
          endcase
        end
        // NRZI decode: no level change is a one
        bs_s      = {line_sample_i == prev_rx_q, bs_q[WORD_BITS:1]};
        prev_rx_d = line_sample_i;
      end
      if (soft_i) begin
        phase_d = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
      end else begin
        phase_d = (phase_q != 2'd0) ? 2'd0 : 2'd1;
      end
      bs_d = bs_s;
      if (bs_s[0]) begin
        rx_word_o       = bs_s[WORD_BITS:1];
        rx_word_valid_o = 1'b1;
        bs_d            = {1'b1, {WORD_BITS{1'b0}}};
      end
      if (arb_q <= 8'd1) begin
        arb_d       = arb_reload;
        arbitrate_o = 1'b1;
      end else begin
        arb_d = arb_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q          <= '0;
      tx_level_q    <= 1'b0;
      prev_sample_q <= 1'b0;
      prev_rx_q     <= 1'b0;
      hist_q        <= '0;
      phase_q       <= '0;
      arb_q         <= '0;
    end else if (adv_i) begin
      bs_q          <= bs_d;
      tx_level_q    <= tx_level_d;
      prev_sample_q <= prev_sample_d;
      prev_rx_q     <= prev_rx_d;
      hist_q        <= hist_d;
      phase_q       <= phase_d;
      arb_q         <= arb_d;
    end
  end

  assign dcd_o.rx_tick = !transmitting_i;
  assign dcd_o.hist    = hist_rx;

endmodule

// ===== rtl/core/afsk_modem_bit_engine.sv =====
// A tick accepted into the input register moves into the result register unless a stalled
// result still holds it. Throughput: one tick per cycle while no result stalls; the whole
// state update is combinational between the input register and the result register,
// which only waits on a stalled result. Reset: rst_ni clears the valid flags, the core and
// carrier-detect state, counters and the mode register asynchronously to zero;
// no clearing pass is needed, and the first receive or transmit tick pulses arbitrate.
`include "assert_macros.svh"

module afsk_modem_bit_engine #(
  parameter int unsigned WORD_BITS = amb_pkg::WORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // s_axis_tdata, low bit up: line_sample, next_tx_word, zero fill
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((WORD_BITS+1+7)/8)*8-1:0]   s_axis_tdata,
  // s_axis_tuser: transmitting
  input  logic                               s_axis_tuser,
  // m_axis_tdata, low bit up: modem_control, next_divisor, tx_word_taken,
  // rx_word, rx_word_valid, dcd_valid, carrier, arbitrate, zero fill
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [((WORD_BITS+13+7)/8)*8-1:0]  m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [amb_pkg::AMB_PADDR_W-1:0]    paddr,
  input  logic [amb_pkg::AMB_DATA_W-1:0]     pwdata,
  output logic [amb_pkg::AMB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import amb_pkg::*;

  localparam int unsigned OUT_TDATA_W = ((WORD_BITS + 13 + 7) / 8) * 8;

  logic                 in_valid_q, in_valid_d;
  logic                 in_xmit_q;
  logic                 in_sample_q;
  logic [WORD_BITS-1:0] in_word_q;
  logic                 out_valid_q, out_valid_d;
  logic                 adv;
  logic                 soft_dcd;

  dcd_in_t              dcd_in;
  dcd_out_t             dcd_out;

  logic [3:0]           ctrl_c, div_c;
  logic                 taken_c, wvalid_c, arb_c;
  logic [WORD_BITS-1:0] word_c;

  logic [3:0]           ctrl_q, div_q;
  logic                 taken_q, wvalid_q, dv_q, car_q, arb_q;
  logic [WORD_BITS-1:0] word_q;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  amb_apb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .soft_dcd_o (soft_dcd)
  );

  amb_bit_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .soft_i          (soft_dcd),
    .transmitting_i  (in_xmit_q),
    .line_sample_i   (in_sample_q),
    .next_tx_word_i  (in_word_q),
    .dcd_o           (dcd_in),
    .modem_control_o (ctrl_c),
    .next_divisor_o  (div_c),
    .tx_word_taken_o (taken_c),
    .rx_word_o       (word_c),
    .rx_word_valid_o (wvalid_c),
    .arbitrate_o     (arb_c)
  );

  amb_dcd u_dcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .soft_i (soft_dcd),
    .dcd_i  (dcd_in),
    .dcd_o  (dcd_out)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the input register until its tick moves into the result register.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_xmit_q   <= s_axis_tuser;
      in_sample_q <= s_axis_tdata[0];
      in_word_q   <= s_axis_tdata[WORD_BITS:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q   <= ctrl_c;
      div_q    <= div_c;
      taken_q  <= taken_c;
      word_q   <= word_c;
      wvalid_q <= wvalid_c;
      dv_q     <= dcd_out.valid;
      car_q    <= dcd_out.carrier;
      arb_q    <= arb_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({arb_q, car_q, dv_q, wvalid_q, word_q,
                                       taken_q, div_q, ctrl_q});

  `AMB_ASSERT_NEXT(a_in_held, in_valid_q && !adv, in_valid_q, "input tick dropped")
  `AMB_ASSERT_NEXT(a_result_shown, adv, m_axis_tvalid, "processed tick not presented")
  `AMB_ASSERT(a_tx_result, m_axis_tvalid && (ctrl_q & 4'he) == CTRL_TX |->
    div_q == DIV_TX && !wvalid_q && !dv_q, "transmit tick with receive result")
  `AMB_ASSERT(a_rx_flags, m_axis_tvalid && (wvalid_q || dv_q) |-> ctrl_q == CTRL_RX,
    "receive flags on a transmit tick")

endmodule
